@@ rtl/bafst_pkg.sv @@
// Shared types and constants for the bump allocator with size-keyed free table.
// No dependencies.
package bafst_pkg;

    localparam logic [31:0] ARENA_RESET = 32'd100000000;

    localparam logic [2:0] ADDR_ARENA = 3'd0;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_REUSED   = 3'd0,
        ST_BUMPED   = 3'd1,
        ST_NO_SPACE = 3'd2,
        ST_FREED    = 3'd3,
        ST_DROPPED  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } t_state;

endpackage

@@ rtl/bafst_mem.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module bafst_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bafst_regs.sv @@
// APB-style configuration register block holding the arena size.
// Depends on bafst_pkg.
module bafst_regs
    import bafst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] o_arena_size
);

    logic [31:0] r_arena;
    logic [31:0] n_arena;

    always_comb begin
        n_arena = r_arena;
        if (psel && penable && pwrite && (paddr == ADDR_ARENA)) begin
            n_arena = pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arena <= ARENA_RESET;
        end else begin
            r_arena <= n_arena;
        end
    end

    assign prdata       = (paddr == ADDR_ARENA) ? r_arena : 32'd0;
    assign pready       = 1'b1;
    assign o_arena_size = r_arena;

endmodule

@@ rtl/bafst_ctrl.sv @@
// Sequencer: walks the free table one slot per cycle, then decides and writes back.
// Depends on bafst_pkg; drives the table RAM ports of bafst_mem.
module bafst_ctrl
    import bafst_pkg::*;
#(
    parameter int FREE_SLOTS = 16,
    parameter int AW         = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [31:0]   i_arena_size,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_kind,
    input  logic [31:0]   i_block_size,
    input  logic [31:0]   i_block_offset,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [31:0]   o_result_offset,
    output logic [2:0]    o_status,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic [63:0]   o_wdata,
    output logic          o_re,
    output logic [AW-1:0] o_raddr,
    input  logic [63:0]   i_rdata
);

    localparam int CW = AW + 1;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_pend, n_pend;
    logic [AW-1:0]   r_rd_idx, n_rd_idx;
    logic            r_kind, n_kind;
    logic [31:0]     r_size, n_size;
    logic [31:0]     r_offset, n_offset;
    logic            r_match_hit, n_match_hit;
    logic [AW-1:0]   r_match_idx, n_match_idx;
    logic            r_empty_hit, n_empty_hit;
    logic [AW-1:0]   r_empty_idx, n_empty_idx;
    logic            r_best_hit, n_best_hit;
    logic [AW-1:0]   r_best_idx, n_best_idx;
    logic [31:0]     r_best_size, n_best_size;
    logic [31:0]     r_best_off, n_best_off;
    logic [31:0]     r_bump, n_bump;
    logic            r_valid [FREE_SLOTS];
    logic            set_valid, clr_valid;
    logic [AW-1:0]   valid_idx;
    logic            r_out_valid, n_out_valid;
    logic [31:0]     r_res_off, n_res_off;
    t_status         r_res_st, n_res_st;
    logic            slot_v;
    logic [31:0]     slot_size;
    logic [31:0]     slot_off;
    logic [32:0]     bump_end;

    assign slot_v    = r_valid[r_rd_idx];
    assign slot_size = i_rdata[63:32];
    assign slot_off  = i_rdata[31:0];
    assign bump_end  = {1'b0, r_bump} + {1'b0, r_size};

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_rd_idx    = r_rd_idx;
        n_kind      = r_kind;
        n_size      = r_size;
        n_offset    = r_offset;
        n_match_hit = r_match_hit;
        n_match_idx = r_match_idx;
        n_empty_hit = r_empty_hit;
        n_empty_idx = r_empty_idx;
        n_best_hit  = r_best_hit;
        n_best_idx  = r_best_idx;
        n_best_size = r_best_size;
        n_best_off  = r_best_off;
        n_bump      = r_bump;
        n_out_valid = r_out_valid && !i_out_ready;
        n_res_off   = r_res_off;
        n_res_st    = r_res_st;
        o_in_ready  = 1'b0;
        o_re        = 1'b0;
        o_raddr     = r_cnt[AW-1:0];
        o_we        = 1'b0;
        o_waddr     = r_match_idx;
        o_wdata     = {r_size, r_offset};
        set_valid   = 1'b0;
        clr_valid   = 1'b0;
        valid_idx   = r_best_idx;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_kind      = i_kind;
                    n_size      = i_block_size;
                    n_offset    = i_block_offset;
                    n_cnt       = '0;
                    n_pend      = 1'b0;
                    n_match_hit = 1'b0;
                    n_empty_hit = 1'b0;
                    n_best_hit  = 1'b0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt != CW'(FREE_SLOTS)) begin
                    o_re     = 1'b1;
                    n_rd_idx = r_cnt[AW-1:0];
                    n_pend   = 1'b1;
                    n_cnt    = r_cnt + CW'(1);
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (slot_v && slot_size == r_size) begin
                        n_match_hit = 1'b1;
                        n_match_idx = r_rd_idx;
                    end
                    if (!slot_v && !r_empty_hit) begin
                        n_empty_hit = 1'b1;
                        n_empty_idx = r_rd_idx;
                    end
                    if (slot_v && slot_size >= r_size &&
                        (!r_best_hit || slot_size < r_best_size)) begin
                        n_best_hit  = 1'b1;
                        n_best_idx  = r_rd_idx;
                        n_best_size = slot_size;
                        n_best_off  = slot_off;
                    end
                    if (r_cnt == CW'(FREE_SLOTS)) begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    n_res_off   = 32'd0;
                    if (r_kind == KIND_FREE) begin
                        if (r_match_hit) begin
                            o_we     = 1'b1;
                            n_res_st = ST_FREED;
                        end else if (r_empty_hit) begin
                            o_we      = 1'b1;
                            o_waddr   = r_empty_idx;
                            set_valid = 1'b1;
                            valid_idx = r_empty_idx;
                            n_res_st  = ST_FREED;
                        end else begin
                            n_res_st = ST_DROPPED;
                        end
                    end else if (r_best_hit) begin
                        clr_valid = 1'b1;
                        n_res_off = r_best_off;
                        n_res_st  = ST_REUSED;
                    end else if (bump_end > {1'b0, i_arena_size}) begin
                        n_res_st = ST_NO_SPACE;
                    end else begin
                        n_res_off = r_bump;
                        n_res_st  = ST_BUMPED;
                        n_bump    = bump_end[31:0];
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_match_hit <= 1'b0;
            r_empty_hit <= 1'b0;
            r_best_hit  <= 1'b0;
            r_bump      <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_match_hit <= n_match_hit;
            r_empty_hit <= n_empty_hit;
            r_best_hit  <= n_best_hit;
            r_bump      <= n_bump;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx    <= n_rd_idx;
        r_kind      <= n_kind;
        r_size      <= n_size;
        r_offset    <= n_offset;
        r_match_idx <= n_match_idx;
        r_empty_idx <= n_empty_idx;
        r_best_idx  <= n_best_idx;
        r_best_size <= n_best_size;
        r_best_off  <= n_best_off;
        r_res_off   <= n_res_off;
        r_res_st    <= n_res_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FREE_SLOTS; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (set_valid) begin
            r_valid[valid_idx] <= 1'b1;
        end else if (clr_valid) begin
            r_valid[valid_idx] <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_offset = r_res_off;
    assign o_status        = r_res_st;

endmodule

@@ rtl/bump_allocator_size_free_table.sv @@
// Bump allocator with a size-keyed free table held in one synchronous RAM.
// One item in flight: a new input beat is accepted only after the slot walk
// over the single RAM read port and the decision/write-back step, and the
// decision waits while an earlier result is still held unaccepted.
// Reset: bump pointer zero, all slots empty, arena size 100000000; RAM
// contents are not cleared. Depends on bafst_pkg, bafst_regs, bafst_ctrl, bafst_mem.
module bump_allocator_size_free_table
    import bafst_pkg::*;
#(
    parameter int FREE_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [31:0] i_block_size,
    input  logic [31:0] i_block_offset,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_result_offset,
    output logic [2:0]  o_status
);

    localparam int AW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;

    logic [31:0]   arena_size;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [63:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [63:0]   mem_rdata;

    bafst_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_arena_size (arena_size)
    );

    bafst_mem #(
        .DEPTH (FREE_SLOTS),
        .AW    (AW),
        .WIDTH (64)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bafst_ctrl #(
        .FREE_SLOTS (FREE_SLOTS),
        .AW         (AW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_arena_size    (arena_size),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_block_size    (i_block_size),
        .i_block_offset  (i_block_offset),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_offset (o_result_offset),
        .o_status        (o_status),
        .o_we            (mem_we),
        .o_waddr         (mem_waddr),
        .o_wdata         (mem_wdata),
        .o_re            (mem_re),
        .o_raddr         (mem_raddr),
        .i_rdata         (mem_rdata)
    );

endmodule
